// ===== hdl/lrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfs_pkg
// shared constants and types for the longest remaining first scheduler
// ----------------------------------------------------------------------------
package lrfs_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic finish;
    } lrfs_cmd_t;

    typedef struct packed {
        logic scan_last;
    } lrfs_status_t;

endpackage

// ===== hdl/longest_remaining_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// longest_remaining_first_scheduler
// preemptive longest-remaining-time-first scheduler over a small slot table
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall): req_type selects a load or a tick.
//   a load writes slot's arrival time and burst length; it gives no result.
//   a load to a slot beyond the table is dropped.
// output channel (out_valid / out_stall): one result per tick with the
//   running slot, completion flag, time after the tick and all-done flag.
// a tick runs in steps: accept, the selection scan over every slot (one
//   slot table read per cycle), then an update of the slot and time counter
//   that also loads the result register.
// in_stall is high while a tick is in progress; loads and the next tick are
//   taken while an earlier result still waits in the output register.
// if the receiver stalls, the result holds; a following tick waits in its
//   update cycle until the output register is free.
// reset clears all slots, the time counter and out_valid.
// ----------------------------------------------------------------------------
module longest_remaining_first_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [1:0]  slot,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        busy_res,
    output logic [1:0]  running_slot,
    output logic        completed,
    output logic [15:0] finish_time,
    output logic        all_done
);

    lrfs_pkg::lrfs_cmd_t    cmd;
    lrfs_pkg::lrfs_status_t status;

    lrfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lrfs_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .slot         (slot),
        .arrival_time (arrival_time),
        .burst_length (burst_length),
        .busy_res     (busy_res),
        .running_slot (running_slot),
        .completed    (completed),
        .finish_time  (finish_time),
        .all_done     (all_done)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan_start, cmd.scan_step, cmd.finish}))
        else $error("more than one datapath command");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("retired tick without result");

    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type == lrfs_pkg::REQ_TICK) |=> in_stall)
        else $error("input taken during tick");

    a_completed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && completed) |-> busy_res)
        else $error("completion on idle tick");

    a_work_left: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && busy_res && !completed) |-> !all_done)
        else $error("all done while running slot has work");

endmodule

// ===== hdl/lrfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrfs_ctrl
// sequencer: accepts requests, steps the slot scan, owns the result valid
// ----------------------------------------------------------------------------
module lrfs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  lrfs_pkg::lrfs_status_t status,
    output lrfs_pkg::lrfs_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == lrfs_pkg::REQ_TICK)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // result register must be free before the tick retires
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/lrfs_datapath.sv =====
// ----------------------------------------------------------------------------
// lrfs_datapath
// slot table, time counter, one-slot-per-cycle selection scan, result register
// ----------------------------------------------------------------------------
module lrfs_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lrfs_pkg::lrfs_cmd_t    cmd,
    output lrfs_pkg::lrfs_status_t status,
    input  logic [1:0]             slot,
    input  logic [15:0]            arrival_time,
    input  logic [15:0]            burst_length,
    output logic                   busy_res,
    output logic [1:0]             running_slot,
    output logic                   completed,
    output logic [15:0]            finish_time,
    output logic                   all_done
);

    localparam int N  = lrfs_pkg::NUM_SLOTS;
    localparam int TB = lrfs_pkg::TIME_BITS;
    localparam int SB = lrfs_pkg::SLOT_BITS;
    localparam int CB = lrfs_pkg::CNT_BITS;

    logic [TB-1:0] work_reg  [N];
    logic [TB-1:0] ready_reg [N];
    logic [TB-1:0] time_reg;
    logic [SB-1:0] idx_reg;
    logic          found_reg;
    logic [SB-1:0] pick_reg;
    logic [TB-1:0] best_reg;
    logic [CB-1:0] nz_cnt_reg;

    logic          busy_reg;
    logic [1:0]    run_slot_reg;
    logic          completed_reg;
    logic [15:0]   finish_time_reg;
    logic          all_done_reg;

    logic [TB-1:0] cur_work;
    logic [TB-1:0] cur_ready;
    logic          cur_nonzero;
    logic          cur_better;
    logic [TB-1:0] time_next;
    logic          done_next;
    logic          load_ok;
    logic [SB-1:0] load_idx;

    assign cur_work    = work_reg[idx_reg];
    assign cur_ready   = ready_reg[idx_reg];
    assign cur_nonzero = (cur_work != '0);
    assign cur_better  = cur_nonzero && (cur_ready <= time_reg)
                         && (!found_reg || (cur_work > best_reg));

    assign status.scan_last = (idx_reg == SB'(N - 1));

    assign time_next = time_reg + 1'b1;
    assign done_next = found_reg && (best_reg == TB'(1));
    assign load_ok   = (32'(slot) < N);
    assign load_idx  = SB'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                work_reg[k]  <= '0;
                ready_reg[k] <= '0;
            end
            time_reg   <= '0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            pick_reg   <= '0;
            best_reg   <= '0;
            nz_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load && load_ok)
            begin
                ready_reg[load_idx] <= TB'(arrival_time);
                work_reg[load_idx]  <= TB'(burst_length);
            end
            if (cmd.scan_start)
            begin
                idx_reg    <= '0;
                found_reg  <= 1'b0;
                pick_reg   <= '0;
                best_reg   <= '0;
                nz_cnt_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                idx_reg    <= idx_reg + 1'b1;
                nz_cnt_reg <= nz_cnt_reg + CB'(cur_nonzero);
                if (cur_better)
                begin
                    found_reg <= 1'b1;
                    pick_reg  <= idx_reg;
                    best_reg  <= cur_work;
                end
            end
            if (cmd.finish)
            begin
                time_reg <= time_next;
                if (found_reg)
                begin
                    work_reg[pick_reg] <= best_reg - 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            busy_reg        <= found_reg;
            run_slot_reg    <= found_reg ? 2'(pick_reg) : 2'd0;
            completed_reg   <= done_next;
            finish_time_reg <= 16'(time_next);
            all_done_reg    <= (nz_cnt_reg == CB'(done_next));
        end
    end

    assign busy_res     = busy_reg;
    assign running_slot = run_slot_reg;
    assign completed    = completed_reg;
    assign finish_time  = finish_time_reg;
    assign all_done     = all_done_reg;

endmodule
